@@ src/tsr_pkg.sv @@
`timescale 1ns / 1ps

package tsr_pkg;

  // Command codes on the request channel
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Control characters of the put stream
  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharBs = 8'd8;

  // Row index width for the largest supported row count (1024 rows)
  localparam int unsigned MaxRowW = 10;

  // Operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [7:0] line_index;
    logic [7:0] col_index;
  } tsr_req_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] live_rows;
  } tsr_rsp_t;

  typedef struct packed {
    op_e                op;
    logic [MaxRowW-1:0] row;
    logic [7:0]         col;
    logic [7:0]         data;
    logic [7:0]         live;
  } tsr_op_t;

endpackage

@@ src/text_scrollback_ring.sv @@
`timescale 1ns / 1ps

// Channel   Ports                 Direction  Beat taken when
// request   start, req_i          in         start high and busy low at the edge
// result    done_o, rsp_o         out        done_o high; one cycle, no back-pressure
//
// Path from accept to result: the beat is queued, then taken into the back end; a put
// computes its address and writes memory, a beat with nothing to do answers from the
// address state, and a read adds memory access and registered read data after the address
// multiply; clear zeroes one row start per cycle through the single memory write port.
// Reset: the store is swept to zero one byte per cycle, with busy held high throughout.
// Stalls: busy rises only while the two-entry queue is full or the sweep runs;
// results leave on done_o in request order and cannot be held off.

module text_scrollback_ring import tsr_pkg::*; #(
  parameter int unsigned ROW_COUNT = 160,
  parameter int unsigned ROW_WIDTH = 200
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tsr_req_t req_i,
  output logic     done_o,
  output tsr_rsp_t rsp_o
);

  logic    accept;
  logic    push;
  tsr_op_t front_op;
  logic    q_valid;
  logic    q_full;
  tsr_op_t q_op;
  logic    pop;
  logic    init;

  // front end takes a beat whenever the queue has room and the store is swept
  assign busy   = q_full | init;
  assign accept = start & ~busy;

  // pointers, classification and row arithmetic
  tsr_front #(
    .ROW_COUNT (ROW_COUNT),
    .ROW_WIDTH (ROW_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .push_o   (push),
    .op_o     (front_op)
  );

  // decouples pointer updates from memory traffic
  tsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .op_o    (q_op)
  );

  // row store, reset sweep, clear walk and result register
  tsr_back #(
    .ROW_COUNT (ROW_COUNT),
    .ROW_WIDTH (ROW_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .op_i    (q_op),
    .pop_o   (pop),
    .init_o  (init),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

@@ src/tsr_front.sv @@
`timescale 1ns / 1ps

module tsr_front import tsr_pkg::*; #(
  parameter int unsigned ROW_COUNT = 160,
  parameter int unsigned ROW_WIDTH = 200
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  tsr_req_t req_i,
  output logic     push_o,
  output tsr_op_t  op_o
);

  localparam int unsigned RW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned CW   = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int unsigned LW   = $clog2(ROW_COUNT + 1);
  localparam int unsigned CmpW = (LW > 8) ? LW : 8;
  localparam int unsigned SW   = ((RW > 8) ? RW : 8) + 1;

  logic [RW-1:0] head_q, head_d;
  logic [RW-1:0] first_q, first_d;
  logic [LW-1:0] live_q, live_d;
  logic [CW-1:0] fill_q, fill_d;

  logic [SW-1:0]   row_sum;
  logic [SW-1:0]   row_wrap;
  logic            line_ok;
  logic            col_ok;
  logic            do_close;
  logic            at_last_col;

  assign row_sum  = SW'(first_q) + SW'(req_i.line_index);
  assign row_wrap = (row_sum >= SW'(ROW_COUNT)) ? row_sum - SW'(ROW_COUNT) : row_sum;
  assign line_ok  = CmpW'(req_i.line_index) < CmpW'(live_q);
  assign col_ok   = {1'b0, req_i.col_index} < 9'(ROW_WIDTH);
  assign at_last_col = {1'b0, fill_q} >= (CW + 1)'(ROW_WIDTH - 1);

  always_comb begin
    head_d   = head_q;
    first_d  = first_q;
    live_d   = live_q;
    fill_d   = fill_q;
    do_close = 1'b0;
    op_o.op   = OP_NONE;
    op_o.row  = MaxRowW'(head_q);
    op_o.col  = 8'(fill_q);
    op_o.data = 8'd0;

    unique case (cmd_e'(req_i.cmd))
      CMD_PUT: begin
        priority if (req_i.char_code == CharCr) begin
          // dropped
        end else if (req_i.char_code == CharLf) begin
          do_close = 1'b1;
        end else if (req_i.char_code == CharBs) begin
          if (fill_q != '0) begin
            fill_d = fill_q - CW'(1);
          end
        end else if (!at_last_col) begin
          op_o.op   = OP_WRITE;
          op_o.data = req_i.char_code;
          fill_d    = fill_q + CW'(1);
        end else begin
          // row full: close it, byte is lost
          do_close = 1'b1;
        end
      end
      CMD_READ: begin
        if (line_ok && col_ok) begin
          op_o.op  = OP_READ;
          op_o.row = MaxRowW'(RW'(row_wrap));
          op_o.col = req_i.col_index;
        end
      end
      CMD_CLEAR: begin
        op_o.op = OP_CLEAR;
        head_d  = '0;
        first_d = '0;
        live_d  = '0;
        fill_d  = '0;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase

    if (do_close) begin
      // terminator at the fill column, then step the ring
      op_o.op = OP_WRITE;
      fill_d  = '0;
      head_d  = (head_q == RW'(ROW_COUNT - 1)) ? '0 : head_q + RW'(1);
      if (live_q < LW'(ROW_COUNT)) begin
        live_d = live_q + LW'(1);
      end else begin
        first_d = (first_q == RW'(ROW_COUNT - 1)) ? '0 : first_q + RW'(1);
      end
    end

    // live count as reported, low eight bits only
    op_o.live = 8'(live_d);
  end

  assign push_o    = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      first_q <= '0;
      live_q  <= '0;
      fill_q  <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      first_q <= first_d;
      live_q  <= live_d;
      fill_q  <= fill_d;
    end
  end

endmodule

@@ src/tsr_queue.sv @@
`timescale 1ns / 1ps

module tsr_queue import tsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  tsr_op_t op_i,
  input  logic    pop_i,
  output logic    valid_o,
  output logic    full_o,
  output tsr_op_t op_o
);

  // two-entry FIFO
  tsr_op_t    slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign op_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ src/tsr_back.sv @@
`timescale 1ns / 1ps

module tsr_back import tsr_pkg::*; #(
  parameter int unsigned ROW_COUNT = 160,
  parameter int unsigned ROW_WIDTH = 200
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  tsr_op_t  op_i,
  output logic     pop_o,
  output logic     init_o,
  output logic     done_o,
  output tsr_rsp_t rsp_o
);

  localparam int unsigned Depth = ROW_COUNT * ROW_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADDR,
    S_MEM,
    S_RD,
    S_CLR
  } state_e;

  state_e        state_q;
  tsr_op_t       op_q;
  logic [AW-1:0] addr_q;
  logic [RW-1:0] clr_row_q;
  logic          done_q;
  tsr_rsp_t      rsp_q;

  logic [7:0]    mem [Depth];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] row_base;
  logic [AW-1:0] addr_calc;

  assign row_base  = AW'(op_q.row[RW-1:0]) * AW'(ROW_WIDTH);
  assign addr_calc = row_base + AW'(op_q.col);

  assign mem_we    = (state_q == S_INIT) || (state_q == S_CLR) ||
                     ((state_q == S_MEM) && (op_q.op == OP_WRITE));
  assign mem_wdata = (state_q == S_MEM) ? op_q.data : 8'd0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rdata_q <= mem[addr_q];
  end

  assign pop_o  = (state_q == S_IDLE) && valid_i;
  assign init_o = state_q == S_INIT;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      op_q      <= '0;
      addr_q    <= '0;
      clr_row_q <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          if (addr_q == AW'(Depth - 1)) begin
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (valid_i) begin
            op_q    <= op_i;
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          unique case (op_q.op)
            OP_WRITE, OP_READ: begin
              addr_q  <= addr_calc;
              state_q <= S_MEM;
            end
            OP_CLEAR: begin
              addr_q    <= '0;
              clr_row_q <= '0;
              state_q   <= S_CLR;
            end
            OP_NONE: begin
              done_q  <= 1'b1;
              rsp_q   <= '{read_char: 8'd0, live_rows: op_q.live};
              state_q <= S_IDLE;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_MEM: begin
          if (op_q.op == OP_READ) begin
            state_q <= S_RD;
          end else begin
            done_q  <= 1'b1;
            rsp_q   <= '{read_char: 8'd0, live_rows: op_q.live};
            state_q <= S_IDLE;
          end
        end
        S_RD: begin
          done_q  <= 1'b1;
          rsp_q   <= '{read_char: rdata_q, live_rows: op_q.live};
          state_q <= S_IDLE;
        end
        S_CLR: begin
          addr_q <= addr_q + AW'(ROW_WIDTH);
          if (clr_row_q == RW'(ROW_COUNT - 1)) begin
            done_q  <= 1'b1;
            rsp_q   <= '{read_char: 8'd0, live_rows: op_q.live};
            state_q <= S_IDLE;
          end else begin
            clr_row_q <= clr_row_q + RW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
